// ===== hdl/psf_pkg.sv =====
// Package for the pendulum state-feedback core.
// Holds widths, register indexes, reset values and shared types.
// No dependencies.
package psf_pkg;

   localparam int COUNT_W  = 32;
   localparam int SAMPLE_W = 12;
   localparam int GAIN_W   = 32;
   localparam int LIMIT_W  = 31;
   localparam int DIR_W    = 2;
   localparam int CMP_W    = 7;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   localparam int OPA_W  = COUNT_W + 1;
   localparam int PROD_W = OPA_W + GAIN_W;
   localparam int ACC_W  = PROD_W + 2;
   localparam int DIFF_W = SAMPLE_W + 1;

   localparam int Q_FRAC     = 24;
   localparam int MAG_W      = LIMIT_W;
   localparam int MAG100_W   = MAG_W + 8;
   localparam int SCALED_W   = MAG100_W - Q_FRAC;
   localparam int DIV3_SHIFT = 17;
   localparam int DUTY_W     = 13;

   localparam logic [GAIN_W-1:0] DIV3_RECIP     = 32'd43691;
   localparam logic [CMP_W-1:0]  COMPARE_OFFSET = 7'd5;
   localparam logic [CMP_W-1:0]  CMP_HW_MAX     = 7'd127;

   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_POSITION     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_VELOCITY     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_ANGLE        = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_ANGULAR_RATE = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ANGLE_ZERO_COUNT  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_DRIVE_LIMIT       = 3'd5;

   localparam logic signed [GAIN_W-1:0] RST_GAIN_POSITION     = -32'sd9350;
   localparam logic signed [GAIN_W-1:0] RST_GAIN_VELOCITY     = -32'sd1397220;
   localparam logic signed [GAIN_W-1:0] RST_GAIN_ANGLE        = -32'sd473926;
   localparam logic signed [GAIN_W-1:0] RST_GAIN_ANGULAR_RATE = -32'sd6269260;
   localparam logic [SAMPLE_W-1:0]      RST_ANGLE_ZERO_COUNT  = 12'd882;
   localparam logic [LIMIT_W-1:0]       RST_DRIVE_LIMIT       = 31'd46976205;

   localparam logic [DIR_W-1:0] DIR_OFF     = 2'd0;
   localparam logic [DIR_W-1:0] DIR_FORWARD = 2'd1;
   localparam logic [DIR_W-1:0] DIR_REVERSE = 2'd2;

   typedef struct packed {
      logic signed [GAIN_W-1:0] gain_position;
      logic signed [GAIN_W-1:0] gain_velocity;
      logic signed [GAIN_W-1:0] gain_angle;
      logic signed [GAIN_W-1:0] gain_angular_rate;
      logic [SAMPLE_W-1:0]      angle_zero_count;
      logic [LIMIT_W-1:0]       drive_limit;
   } psf_cfg_type;

   typedef struct packed {
      logic mul_en;
      logic acc_clear;
      logic acc_en;
   } psf_mac_ctrl_type;

endpackage

// ===== hdl/psf_channels.sv =====
// Channel interfaces of the pendulum state-feedback core.
// Request, response and register-write channels; depends on psf_pkg.
interface psf_req_if import psf_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [COUNT_W-1:0]  encoder_count;
   logic [SAMPLE_W-1:0]        angle_sample;
   modport source (output valid, encoder_count, angle_sample, input ready);
   modport sink   (input valid, encoder_count, angle_sample, output ready);
endinterface

interface psf_rsp_if import psf_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [COUNT_W-1:0]  drive_value;
   logic [DIR_W-1:0]           direction;
   logic [CMP_W-1:0]           compare_value;
   logic                       saturated;
   modport source (output valid, drive_value, direction, compare_value, saturated,
                   input ready);
   modport sink   (input valid, drive_value, direction, compare_value, saturated,
                   output ready);
endinterface

interface psf_csr_if import psf_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CSR_IDX_W-1:0]   index;
   logic [CSR_DATA_W-1:0]  data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/psf_csr_regs.sv =====
// Configuration registers of the pendulum state-feedback core.
// Takes writes from the csr channel; depends on psf_pkg and psf_channels.
module psf_csr_regs import psf_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   psf_csr_if.sink       csr,
   output psf_cfg_type   cfg
);

   psf_cfg_type cfg_ff;
   psf_cfg_type cfg_in;

   assign csr.ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr.valid) begin
         case (csr.index)
            CSR_GAIN_POSITION:     cfg_in.gain_position     = $signed(csr.data);
            CSR_GAIN_VELOCITY:     cfg_in.gain_velocity     = $signed(csr.data);
            CSR_GAIN_ANGLE:        cfg_in.gain_angle        = $signed(csr.data);
            CSR_GAIN_ANGULAR_RATE: cfg_in.gain_angular_rate = $signed(csr.data);
            CSR_ANGLE_ZERO_COUNT:  cfg_in.angle_zero_count  = csr.data[SAMPLE_W-1:0];
            CSR_DRIVE_LIMIT:       cfg_in.drive_limit       = csr.data[LIMIT_W-1:0];
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_position     <= RST_GAIN_POSITION;
         cfg_ff.gain_velocity     <= RST_GAIN_VELOCITY;
         cfg_ff.gain_angle        <= RST_GAIN_ANGLE;
         cfg_ff.gain_angular_rate <= RST_GAIN_ANGULAR_RATE;
         cfg_ff.angle_zero_count  <= RST_ANGLE_ZERO_COUNT;
         cfg_ff.drive_limit       <= RST_DRIVE_LIMIT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== hdl/psf_mac.sv =====
// Shared multiply-accumulate unit of the pendulum state-feedback core.
// Registered 33x32 signed product feeding a wide accumulator; depends on psf_pkg.
module psf_mac import psf_pkg::*; (
   input  logic                       clock,
   input  psf_mac_ctrl_type           ctrl,
   input  logic signed [OPA_W-1:0]    op_a,
   input  logic signed [GAIN_W-1:0]   op_b,
   output logic signed [PROD_W-1:0]   product,
   output logic signed [ACC_W-1:0]    acc
);

   logic signed [PROD_W-1:0] product_ff;
   logic signed [PROD_W-1:0] product_in;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [ACC_W-1:0]  acc_in;

   always_comb begin
      product_in = ctrl.mul_en ? PROD_W'(op_a) * PROD_W'(op_b) : product_ff;
      if (ctrl.acc_clear) begin
         acc_in = '0;
      end else if (ctrl.acc_en) begin
         acc_in = acc_ff + ACC_W'(product_ff);
      end else begin
         acc_in = acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      product_ff <= product_in;
      acc_ff     <= acc_in;
   end

   assign product = product_ff;
   assign acc     = acc_ff;

endmodule

// ===== hdl/pendulum_state_feedback_core.sv =====
// Pendulum state-feedback core, top level: sequencer, clamp and PWM mapping.
// Depends on psf_pkg, psf_channels, psf_csr_regs and psf_mac.
//
// Each transfer on req_if is one control tick. The core forms the Q8.24 drive
// u = g_pos*count + g_vel*dcount + g_ang*(sample-zero) + g_rate*dsample with
// one shared signed multiplier and accumulator, clamps it to +/-drive_limit
// and maps it to a direction and a PWM compare count. An item passes through
// four multiplier passes, one accumulate, the clamp, a divide-by-3 pass through
// the same multiplier and the direction and compare mapping before its result
// is registered; the sequencer then returns to idle, so a new tick is taken
// only after the previous tick's result is registered. req_if.ready is high
// only while the sequencer is idle; the result sits in an output register, so
// a new tick is taken while the previous result waits on rsp_if, and the last
// step holds while an earlier result is still waiting. The first tick after
// reset uses zero differences. Register writes are taken any cycle.
module pendulum_state_feedback_core import psf_pkg::*; #(
   parameter int PWM_TOP = 99
) (
   input  logic      clock,
   input  logic      reset,
   psf_req_if.sink   req_if,
   psf_rsp_if.source rsp_if,
   psf_csr_if.sink   csr_if
);

   localparam logic [CMP_W-1:0] CMP_CAP =
      (PWM_TOP < int'(CMP_HW_MAX)) ? CMP_W'(PWM_TOP) : CMP_HW_MAX;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_MUL   = 3'd1;
   localparam logic [2:0] ST_DRAIN = 3'd2;
   localparam logic [2:0] ST_CLAMP = 3'd3;
   localparam logic [2:0] ST_SCALE = 3'd4;
   localparam logic [2:0] ST_DUTY  = 3'd5;

   psf_cfg_type      cfg;
   psf_mac_ctrl_type mac_ctrl;

   logic [2:0] state_ff, state_in;
   logic [1:0] step_ff, step_in;
   logic       primed_ff, primed_in;
   logic signed [COUNT_W-1:0] prev_count_ff, prev_count_in;
   logic [SAMPLE_W-1:0]       prev_sample_ff, prev_sample_in;

   logic signed [OPA_W-1:0]   dpos_ff, dpos_in;
   logic signed [OPA_W-1:0]   dvel_ff, dvel_in;
   logic signed [DIFF_W-1:0]  dang_ff, dang_in;
   logic signed [DIFF_W-1:0]  drate_ff, drate_in;
   logic signed [COUNT_W-1:0] u_ff, u_in;
   logic                      sat_ff, sat_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [COUNT_W-1:0] out_drive_ff, out_drive_in;
   logic [DIR_W-1:0]          out_dir_ff, out_dir_in;
   logic [CMP_W-1:0]          out_cmp_ff, out_cmp_in;
   logic                      out_sat_ff, out_sat_in;

   logic signed [OPA_W-1:0]   op_a;
   logic signed [GAIN_W-1:0]  op_b;
   logic signed [PROD_W-1:0]  product;
   logic signed [ACC_W-1:0]   acc;

   logic signed [COUNT_W-1:0] prev_c_sel;
   logic [SAMPLE_W-1:0]       prev_s_sel;
   logic signed [ACC_W-1:0]   lim_pos, lim_neg;
   logic [COUNT_W-1:0]        mag_full;
   logic [MAG100_W-1:0]       mag100;
   logic [SCALED_W-1:0]       scaled;
   logic [DUTY_W-1:0]         duty;
   logic [DUTY_W:0]           cmp_sum;
   logic                      accept;
   logic                      out_free;

   psf_csr_regs u_csr (
      .clock (clock),
      .reset (reset),
      .csr   (csr_if),
      .cfg   (cfg)
   );

   psf_mac u_mac (
      .clock   (clock),
      .ctrl    (mac_ctrl),
      .op_a    (op_a),
      .op_b    (op_b),
      .product (product),
      .acc     (acc)
   );

   assign req_if.ready = (state_ff == ST_IDLE);
   assign accept       = req_if.valid && req_if.ready;
   assign out_free     = !rsp_valid_ff || rsp_if.ready;

   assign prev_c_sel = primed_ff ? prev_count_ff  : req_if.encoder_count;
   assign prev_s_sel = primed_ff ? prev_sample_ff : req_if.angle_sample;

   assign lim_pos  = $signed(ACC_W'(cfg.drive_limit));
   assign lim_neg  = -lim_pos;
   assign mag_full = u_ff[COUNT_W-1] ? COUNT_W'(-u_ff) : COUNT_W'(u_ff);
   assign mag100   = (MAG100_W'(mag_full[MAG_W-1:0]) << 6)
                   + (MAG100_W'(mag_full[MAG_W-1:0]) << 5)
                   + (MAG100_W'(mag_full[MAG_W-1:0]) << 2);
   assign scaled   = mag100[MAG100_W-1:Q_FRAC];
   assign duty     = product[DIV3_SHIFT+DUTY_W-1:DIV3_SHIFT];
   assign cmp_sum  = (DUTY_W+1)'(duty) + (DUTY_W+1)'(COMPARE_OFFSET);

   // operand select for the shared multiplier
   always_comb begin
      op_a = dpos_ff;
      op_b = cfg.gain_position;
      if (state_ff == ST_SCALE) begin
         op_a = $signed(OPA_W'(scaled));
         op_b = $signed(DIV3_RECIP);
      end else begin
         case (step_ff)
            2'd0: begin
               op_a = dpos_ff;
               op_b = cfg.gain_position;
            end
            2'd1: begin
               op_a = OPA_W'(dang_ff);
               op_b = cfg.gain_angle;
            end
            2'd2: begin
               op_a = OPA_W'(drate_ff);
               op_b = cfg.gain_angular_rate;
            end
            default: begin
               op_a = dvel_ff;
               op_b = cfg.gain_velocity;
            end
         endcase
      end
   end

   always_comb begin
      state_in       = state_ff;
      step_in        = step_ff;
      primed_in      = primed_ff;
      prev_count_in  = prev_count_ff;
      prev_sample_in = prev_sample_ff;
      dpos_in        = dpos_ff;
      dvel_in        = dvel_ff;
      dang_in        = dang_ff;
      drate_in       = drate_ff;
      u_in           = u_ff;
      sat_in         = sat_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_if.ready;
      out_drive_in   = out_drive_ff;
      out_dir_in     = out_dir_ff;
      out_cmp_in     = out_cmp_ff;
      out_sat_in     = out_sat_ff;
      mac_ctrl       = '0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               dpos_in  = OPA_W'(req_if.encoder_count);
               dvel_in  = OPA_W'(req_if.encoder_count) - OPA_W'(prev_c_sel);
               dang_in  = $signed({1'b0, req_if.angle_sample})
                        - $signed({1'b0, cfg.angle_zero_count});
               drate_in = $signed({1'b0, req_if.angle_sample})
                        - $signed({1'b0, prev_s_sel});
               prev_count_in      = req_if.encoder_count;
               prev_sample_in     = req_if.angle_sample;
               primed_in          = 1'b1;
               step_in            = '0;
               mac_ctrl.acc_clear = 1'b1;
               state_in           = ST_MUL;
            end
         end
         ST_MUL: begin
            mac_ctrl.mul_en = 1'b1;
            mac_ctrl.acc_en = (step_ff != 2'd0);
            step_in         = step_ff + 2'd1;
            if (step_ff == 2'd3) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            mac_ctrl.acc_en = 1'b1;
            state_in        = ST_CLAMP;
         end
         ST_CLAMP: begin
            sat_in = 1'b0;
            u_in   = acc[COUNT_W-1:0];
            if (acc > lim_pos) begin
               u_in   = lim_pos[COUNT_W-1:0];
               sat_in = 1'b1;
            end else if (acc < lim_neg) begin
               u_in   = lim_neg[COUNT_W-1:0];
               sat_in = 1'b1;
            end
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            mac_ctrl.mul_en = 1'b1;
            state_in        = ST_DUTY;
         end
         ST_DUTY: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               out_drive_in = u_ff;
               out_sat_in   = sat_ff;
               if (u_ff == '0) begin
                  out_dir_in = DIR_OFF;
                  out_cmp_in = '0;
               end else begin
                  out_dir_in = u_ff[COUNT_W-1] ? DIR_REVERSE : DIR_FORWARD;
                  out_cmp_in = (cmp_sum > (DUTY_W+1)'(CMP_CAP)) ? CMP_CAP
                                                                : cmp_sum[CMP_W-1:0];
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         step_ff        <= '0;
         primed_ff      <= 1'b0;
         prev_count_ff  <= '0;
         prev_sample_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         step_ff        <= step_in;
         primed_ff      <= primed_in;
         prev_count_ff  <= prev_count_in;
         prev_sample_ff <= prev_sample_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dpos_ff      <= dpos_in;
      dvel_ff      <= dvel_in;
      dang_ff      <= dang_in;
      drate_ff     <= drate_in;
      u_ff         <= u_in;
      sat_ff       <= sat_in;
      out_drive_ff <= out_drive_in;
      out_dir_ff   <= out_dir_in;
      out_cmp_ff   <= out_cmp_in;
      out_sat_ff   <= out_sat_in;
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.drive_value   = out_drive_ff;
   assign rsp_if.direction     = out_dir_ff;
   assign rsp_if.compare_value = out_cmp_ff;
   assign rsp_if.saturated     = out_sat_ff;

   a_accept_starts_mul: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_MUL) && (step_ff == 2'd0))
      else $error("sequencer did not start multiplier passes after transfer");

   a_off_means_zero_cmp: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> ((rsp_if.direction == DIR_OFF) == (rsp_if.compare_value == '0)))
      else $error("direction off and compare count disagree");

   a_off_means_zero_drive: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> ((rsp_if.direction == DIR_OFF) == (rsp_if.drive_value == '0)))
      else $error("direction off and drive value disagree");

   a_result_from_duty: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_DUTY))
      else $error("result registered outside the final step");

endmodule

// ===== verif/tb_pendulum_state_feedback_core.sv =====
// Self-checking testbench for pendulum_state_feedback_core: drives control ticks and register
// writes, predicts the clamped drive, direction, compare count and saturation flag per tick.
// Depends on psf_pkg, psf_channels and the core RTL.
module tb_pendulum_state_feedback_core import psf_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PWM_TOP = 99;
   localparam int CYCLE_LIMIT = 600000;
   localparam int RANDOM_PHASES = 12;
   localparam int TICKS_PER_PHASE = 146;
   localparam int MAX_REPORTS = 100;
   localparam longint unsigned VOLT_Q = 64'd1 << Q_FRAC;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_A = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_B = 3'd7;
   localparam logic signed [COUNT_W-1:0] COUNT_MIN = 32'sh8000_0000;
   localparam logic signed [COUNT_W-1:0] COUNT_MAX = 32'sh7FFF_FFFF;

   typedef struct packed {
      logic signed [COUNT_W-1:0] count;
      logic [SAMPLE_W-1:0]       sample;
   } ctl_tick_type;

   typedef struct packed {
      logic signed [COUNT_W-1:0] drive_value;
      logic [DIR_W-1:0]          direction;
      logic [CMP_W-1:0]          compare_value;
      logic                      saturated;
   } drive_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   psf_req_if req_if();
   psf_rsp_if rsp_if();
   psf_csr_if csr_if();

   pendulum_state_feedback_core #(.PWM_TOP(PWM_TOP)) u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // controller copy: gains, limit and tick history
   logic signed [GAIN_W-1:0] k_position = RST_GAIN_POSITION;
   logic signed [GAIN_W-1:0] k_velocity = RST_GAIN_VELOCITY;
   logic signed [GAIN_W-1:0] k_angle    = RST_GAIN_ANGLE;
   logic signed [GAIN_W-1:0] k_rate     = RST_GAIN_ANGULAR_RATE;
   logic [SAMPLE_W-1:0]      k_zero     = RST_ANGLE_ZERO_COUNT;
   logic [LIMIT_W-1:0]       k_limit    = RST_DRIVE_LIMIT;
   logic signed [COUNT_W-1:0] last_count   = '0;
   logic [SAMPLE_W-1:0]       last_sample  = '0;
   logic                      have_history = 1'b0;

   ctl_tick_type     pending_ticks[$];
   drive_result_type expected_drive[$];
   int  fault_count = 0;
   int  cycle_count = 0;
   int  send_idle_pct = 18;
   int  recv_idle_pct = 84;
   logic tick_taken = 1'b0;

   task automatic report_fault(input string msg);
      fault_count++;
      if (fault_count <= MAX_REPORTS) $display("mismatch at %0t: %s", $time, msg);
   endtask

   task automatic apply_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      case (idx)
         CSR_GAIN_POSITION:     k_position = val;
         CSR_GAIN_VELOCITY:     k_velocity = val;
         CSR_GAIN_ANGLE:        k_angle    = val;
         CSR_GAIN_ANGULAR_RATE: k_rate     = val;
         CSR_ANGLE_ZERO_COUNT:  k_zero     = val[SAMPLE_W-1:0];
         CSR_DRIVE_LIMIT:       k_limit    = val[LIMIT_W-1:0];
         default: ;
      endcase
   endtask

   function automatic drive_result_type predict_drive(input logic signed [COUNT_W-1:0] count,
                                                      input logic [SAMPLE_W-1:0] sample);
      longint signed c, pc, s, ps, z, part, vel;
      logic signed [67:0] u, v, lim;
      longint unsigned mag, duty, cap;
      drive_result_type r;
      c  = count;
      s  = sample;
      z  = k_zero;
      pc = have_history ? last_count : count;
      ps = have_history ? last_sample : sample;
      // first tick: both differences vanish
      part = k_position * c + k_angle * (s - z) + k_rate * (s - ps);
      vel  = k_velocity * (c - pc);
      u = part;
      v = vel;
      u = u + v;
      lim = k_limit;
      r.saturated = 1'b0;
      if (u > lim) begin
         u = lim;
         r.saturated = 1'b1;
      end else if (u < -lim) begin
         u = -lim;
         r.saturated = 1'b1;
      end
      r.drive_value = u[COUNT_W-1:0];
      if (u == 0) begin
         r.direction = DIR_OFF;
         r.compare_value = '0;
      end else begin
         r.direction = (u > 0) ? DIR_FORWARD : DIR_REVERSE;
         mag  = 64'((u > 0) ? u : -u);
         duty = (mag * 100) / (3 * VOLT_Q) + COMPARE_OFFSET;
         cap  = (PWM_TOP < CMP_HW_MAX) ? PWM_TOP : CMP_HW_MAX;
         if (duty > cap) duty = cap;
         r.compare_value = duty[CMP_W-1:0];
      end
      last_count   = count;
      last_sample  = sample;
      have_history = 1'b1;
      return r;
   endfunction

   // monitor: transfers are sampled at the rising edge
   always @(posedge clock) begin
      drive_result_type want;
      tick_taken <= !reset && req_if.valid && req_if.ready;
      if (!reset) begin
         if (csr_if.valid && csr_if.ready) apply_reg(csr_if.index, csr_if.data);
         if (req_if.valid && req_if.ready)
            expected_drive.push_back(predict_drive(req_if.encoder_count, req_if.angle_sample));
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_drive.size() == 0) begin
               report_fault("result with no tick outstanding");
            end else begin
               want = expected_drive.pop_front();
               if (rsp_if.drive_value !== want.drive_value)
                  report_fault($sformatf("drive_value got %0d want %0d",
                                         rsp_if.drive_value, want.drive_value));
               if (rsp_if.direction !== want.direction)
                  report_fault($sformatf("direction got %0d want %0d",
                                         rsp_if.direction, want.direction));
               if (rsp_if.compare_value !== want.compare_value)
                  report_fault($sformatf("compare_value got %0d want %0d",
                                         rsp_if.compare_value, want.compare_value));
               if (rsp_if.saturated !== want.saturated)
                  report_fault($sformatf("saturated got %0b want %0b",
                                         rsp_if.saturated, want.saturated));
            end
         end
      end
   end

   // tick driver: changes on the falling edge
   always @(negedge clock) begin
      ctl_tick_type t;
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || tick_taken) begin
         if (pending_ticks.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            t = pending_ticks.pop_front();
            req_if.valid         <= 1'b1;
            req_if.encoder_count <= t.count;
            req_if.angle_sample  <= t.sample;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      rsp_if.ready <= !reset && ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= val;
      do @(posedge clock); while (!csr_if.ready);
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   task automatic load_gains(input logic [31:0] gp, input logic [31:0] gv, input logic [31:0] ga,
                             input logic [31:0] gr, input logic [31:0] zero,
                             input logic [31:0] lim);
      write_reg(CSR_GAIN_POSITION, gp);
      write_reg(CSR_GAIN_VELOCITY, gv);
      write_reg(CSR_GAIN_ANGLE, ga);
      write_reg(CSR_GAIN_ANGULAR_RATE, gr);
      write_reg(CSR_ANGLE_ZERO_COUNT, zero);
      write_reg(CSR_DRIVE_LIMIT, lim);
   endtask

   task automatic queue_tick(input logic signed [COUNT_W-1:0] c, input int s);
      ctl_tick_type t;
      t.count  = c;
      t.sample = s[SAMPLE_W-1:0];
      pending_ticks.push_back(t);
   endtask

   task automatic wait_drained();
      do @(posedge clock);
      while (pending_ticks.size() != 0 || req_if.valid || expected_drive.size() != 0);
   endtask

   function automatic logic [31:0] signed_gain(input int unsigned span);
      int g;
      g = int'($urandom_range(span));
      return $urandom_range(1) ? -g : g;
   endfunction

   initial begin
      int p, i, r, walk, smp;
      req_if.valid = 1'b0;
      req_if.encoder_count = '0;
      req_if.angle_sample = '0;
      rsp_if.ready = 1'b0;
      csr_if.valid = 1'b0;
      csr_if.index = '0;
      csr_if.data = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset gains: first tick, zero drive, extremes, mid-range duty
      queue_tick(1000, 900);
      queue_tick(0, 882);
      queue_tick(0, 882);
      queue_tick(COUNT_MAX, 4095);
      queue_tick(COUNT_MIN, 0);
      queue_tick(-1, 0);
      queue_tick(5, 880);
      queue_tick(7, 884);
      queue_tick(7, 884);
      wait_drained();

      // drive landing exactly on the limit
      load_gains(32'd1, 32'd0, 32'd0, 32'd0, 32'd0, 32'd1000);
      queue_tick(1000, 0);
      queue_tick(1001, 0);
      queue_tick(-1000, 0);
      queue_tick(-1001, 0);
      queue_tick(0, 0);
      queue_tick(1, 0);
      wait_drained();

      // zero limit
      write_reg(CSR_DRIVE_LIMIT, 32'd0);
      queue_tick(5, 0);
      queue_tick(5, 0);
      queue_tick(-5, 0);
      wait_drained();

      // extreme gains: 64-bit sum overflows both ways, duty capped
      load_gains(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      write_reg(CSR_SPARE_A, $urandom());
      write_reg(CSR_SPARE_B, $urandom());
      queue_tick(COUNT_MIN, 0);
      queue_tick(COUNT_MAX, 4095);
      queue_tick(COUNT_MIN, 0);
      wait_drained();

      for (p = 0; p < RANDOM_PHASES; p++) begin
         case (p * 3 / RANDOM_PHASES)
            0: begin send_idle_pct = 18; recv_idle_pct = 84; end
            1: begin send_idle_pct = 84; recv_idle_pct = 18; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         r = $urandom_range(9);
         if (r < 3)
            load_gains(RST_GAIN_POSITION, RST_GAIN_VELOCITY, RST_GAIN_ANGLE,
                       RST_GAIN_ANGULAR_RATE,
                       {20'($urandom_range(1048575)), RST_ANGLE_ZERO_COUNT},
                       {1'($urandom_range(1)), RST_DRIVE_LIMIT});
         else if (r < 8)
            load_gains(signed_gain(1 << 14), signed_gain(1 << 21), signed_gain(1 << 20),
                       signed_gain(1 << 23), $urandom(),
                       {1'($urandom_range(1)), 31'($urandom_range(1 << 27))});
         else
            load_gains($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
         if ($urandom_range(3) == 0) write_reg($urandom_range(1) ? CSR_SPARE_A : CSR_SPARE_B,
                                               $urandom());
         walk = 0;
         for (i = 0; i < TICKS_PER_PHASE; i++) begin
            r = $urandom_range(99);
            if (r < 75) begin
               walk = walk + int'($urandom_range(80)) - 40;
               smp = int'(k_zero) + int'($urandom_range(60)) - 30;
               if (smp < 0) smp = 0;
               if (smp > 4095) smp = 4095;
               queue_tick(walk, smp);
            end else if (r < 92) begin
               queue_tick($urandom(), $urandom_range(4095));
            end else begin
               case ($urandom_range(3))
                  0: queue_tick(COUNT_MIN, $urandom_range(1) ? 4095 : 0);
                  1: queue_tick(COUNT_MAX, $urandom_range(1) ? 4095 : 0);
                  2: queue_tick(0, $urandom_range(1) ? 4095 : 0);
                  default: queue_tick(-1, $urandom_range(1) ? 4095 : 0);
               endcase
            end
         end
         wait_drained();
      end

      repeat (16) @(posedge clock);
      if (expected_drive.size() != 0) report_fault("ticks left without a result");
      if (fault_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/psf_pkg.sv
hdl/psf_channels.sv
hdl/psf_csr_regs.sv
hdl/psf_mac.sv
hdl/pendulum_state_feedback_core.sv
verif/tb_pendulum_state_feedback_core.sv
